// ===== design/mtgp_pkg.sv =====
// Shared types, character codes and label tables for the tele-information group parser.
`timescale 1ns / 1ps
`default_nettype none

package mtgp_pkg;

  localparam int MAX_GROUP_BYTES = 512;
  localparam int GROUP_LEN_W     = 10;
  localparam int TIMEOUT_W       = 16;
  localparam int VALUE_W         = 30;
  localparam int CHAR_W          = 7;
  localparam int LABEL_COUNT     = 6;
  localparam int LABEL_MAX_LEN   = 7;
  localparam int LABEL_POS_W     = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;
  localparam logic [VALUE_W-1:0]   VALUE_MAX     = 30'd999999999;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CHAR_W-1:0] CH_STX  = 7'h02;
  localparam logic [CHAR_W-1:0] CH_ETX  = 7'h03;
  localparam logic [CHAR_W-1:0] CH_EOT  = 7'h04;
  localparam logic [CHAR_W-1:0] CH_LF   = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SP   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 7'h39;

  localparam logic [2:0] LABEL_OTHER = 3'd0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CKSUM_BAD   = 3'd1,
    ST_NO_CK_SEP   = 3'd2,
    ST_NO_DATA_SEP = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  localparam logic [8*LABEL_MAX_LEN-1:0] LABEL_TEXT [LABEL_COUNT] = '{
    "OPTARIF",
    {"PTEC", 24'h0},
    {"ADPS", 24'h0},
    {"PAPP", 24'h0},
    {"HCHC", 24'h0},
    {"HCHP", 24'h0}
  };

  localparam logic [LABEL_POS_W-1:0] LABEL_LEN [LABEL_COUNT] = '{
    3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    status_e            group_status;
    logic [2:0]         label_code;
    logic [VALUE_W-1:0] data_value;
    logic [CHAR_W-1:0]  checksum_received;
    logic [CHAR_W-1:0]  checksum_computed;
  } out_item_t;

  function automatic logic label_char_hit(input int k, input logic [LABEL_POS_W-1:0] pos,
                                          input logic [CHAR_W-1:0] c);
    logic [7:0] ch;
    logic       hit;
    hit = 1'b0;
    if (pos < LABEL_LEN[k]) begin
      ch  = LABEL_TEXT[k][8*(LABEL_MAX_LEN-1-int'(pos)) +: 8];
      hit = (ch[CHAR_W-1:0] == c);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== design/meter_teleinfo_group_parser_top.sv =====
// Top level of the tele-information group parser: group state, checksum, label and value logic.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock while in_stall_o is low (a meter character or a 100 ms
// tick), a rate set by the combinational state update (byte sum, label match, decimal
// accumulate with saturation), and updates the group state in the same cycle it is
// accepted. A CR that closes a group, or a byte past the group length limit, yields one
// result into the output register or, if stalled, its one skid entry; input stall only
// rises when both hold results not yet taken. The idle timeout register resets to 30 ticks;
// the user must write it via cfg_we_i / cfg_wdata_i only while idle; the block does not check.
module meter_teleinfo_group_parser_top
  import mtgp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [TIMEOUT_W-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  typedef struct packed {
    logic                   in_group;
    logic [GROUP_LEN_W-1:0] len;
    logic [7:0]             sum;
    logic [CHAR_W-1:0]      last;
    logic [CHAR_W-1:0]      slast;
    logic                   label_done;
    logic [LABEL_COUNT-1:0] mask;
    logic [LABEL_POS_W-1:0] pos;
    logic [VALUE_W-1:0]     value;
    logic                   digits;
  } grp_t;

  function automatic grp_t clear_grp(input logic active);
    grp_t g;
    g            = '0;
    g.in_group   = active;
    g.mask       = '1;
    g.digits     = 1'b1;
    return g;
  endfunction

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [TIMEOUT_W-1:0] idle_q, idle_d;
  grp_t                 grp_q, grp_d, grp_commit;
  logic                 accept;
  logic                 res_valid;
  out_item_t            res;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  logic                 skid_valid_q, skid_valid_d;
  out_item_t            skid_q, skid_d;
  logic                 out_ready;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = skid_valid_q;

  // Commit of the byte two places back into sum, label and value.
  always_comb begin
    logic [CHAR_W-1:0]  c2;
    logic [VALUE_W+3:0] prod;
    grp_commit = grp_q;
    c2         = grp_q.slast;
    prod       = {grp_q.value, 3'b000} + {2'b00, grp_q.value, 1'b0}
                 + {30'd0, c2[3:0]};
    grp_commit.sum = grp_q.sum + {1'b0, c2};
    if (!grp_q.label_done) begin
      if (c2 == CH_SP) begin
        grp_commit.label_done = 1'b1;
      end else begin
        for (int k = 0; k < LABEL_COUNT; k++) begin
          grp_commit.mask[k] = grp_q.mask[k] && label_char_hit(k, grp_q.pos, c2);
        end
        if (grp_q.pos < LABEL_POS_W'(LABEL_MAX_LEN)) begin
          grp_commit.pos = grp_q.pos + 3'd1;
        end
      end
    end else if (grp_q.digits) begin
      if (c2 >= CH_ZERO && c2 <= CH_NINE) begin
        grp_commit.value = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];
      end else begin
        grp_commit.digits = 1'b0;
      end
    end
  end

  always_comb begin
    logic [CHAR_W-1:0]      c;
    logic [TIMEOUT_W-1:0]   idle_inc;
    logic [CHAR_W-1:0]      computed;
    status_e                st;
    logic [2:0]             code;
    grp_d     = grp_q;
    idle_d    = idle_q;
    res_valid = 1'b0;
    res       = '0;
    c         = in_data_i.char_code;
    idle_inc  = (idle_q < timeout_q) ? idle_q + 16'd1 : idle_q;
    computed  = {1'b0, grp_q.sum[5:0]} + CH_SP;
    code      = LABEL_OTHER;
    for (int k = LABEL_COUNT - 1; k >= 0; k--) begin
      if (grp_q.mask[k] && grp_q.pos == LABEL_LEN[k]) begin
        code = 3'(k + 1);
      end
    end
    priority if (grp_q.len < GROUP_LEN_W'(4) || computed != grp_q.last) begin
      st = ST_CKSUM_BAD;
    end else if (grp_q.slast != CH_SP) begin
      st = ST_NO_CK_SEP;
    end else if (!grp_q.label_done) begin
      st = ST_NO_DATA_SEP;
    end else begin
      st = ST_OK;
    end
    if (accept) begin
      if (in_data_i.command == CMD_TICK) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          grp_d = clear_grp(1'b0);
        end
      end else begin
        idle_d = '0;
        priority if (c == CH_STX || c == CH_ETX) begin
          grp_d = grp_q;
        end else if (c == CH_EOT) begin
          grp_d = clear_grp(1'b0);
        end else if (c == CH_LF) begin
          grp_d = clear_grp(1'b1);
        end else if (!grp_q.in_group) begin
          grp_d = grp_q;
        end else if (c == CH_CR) begin
          res_valid             = 1'b1;
          res.group_status      = st;
          res.label_code        = (st == ST_OK) ? code : LABEL_OTHER;
          res.data_value        = (st == ST_OK) ? grp_q.value : '0;
          res.checksum_received = grp_q.last;
          res.checksum_computed = computed;
          grp_d                 = clear_grp(1'b0);
        end else if (grp_q.len >= GROUP_LEN_W'(MAX_GROUP_BYTES)) begin
          res_valid        = 1'b1;
          res.group_status = ST_OVERFLOW;
          grp_d            = clear_grp(1'b0);
        end else begin
          grp_d       = (grp_q.len >= GROUP_LEN_W'(2)) ? grp_commit : grp_q;
          grp_d.slast = grp_q.last;
          grp_d.last  = c;
          grp_d.len   = grp_q.len + 10'd1;
        end
      end
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RESET;
      idle_q       <= TIMEOUT_RESET;
      grp_q        <= clear_grp(1'b0);
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      idle_q       <= idle_d;
      grp_q        <= grp_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q.len <= GROUP_LEN_W'(MAX_GROUP_BYTES))
    else $error("group length past limit");

  a_idle_group_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !grp_q.in_group |-> (grp_q.len == '0 && grp_q.sum == '0))
    else $error("bytes held outside a group");

  a_char_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.command == CMD_CHAR) |=> idle_q == '0)
    else $error("idle counter not cleared by character");

  a_overflow_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.group_status == ST_OVERFLOW) |->
      (out_data_o.label_code == LABEL_OTHER && out_data_o.data_value == '0))
    else $error("overflow result carries label or value");

endmodule

`default_nettype wire
